// File: rtl/arcade_drive_mixer_top_defines.svh
// ----------------------------------------------------------------------------
// Arcade drive mixer assertion macros
// Shared concurrent assertion forms for the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ARCADE_DRIVE_MIXER_TOP_DEFINES_SVH
`define ARCADE_DRIVE_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define AMX_ASSERT_IMPL(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("amx assertion failed");

// Next-cycle implication, disabled while in reset
`define AMX_ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> cons) \
        else $error("amx assertion failed");

`endif

// File: rtl/amx_pkg.sv
// ----------------------------------------------------------------------------
// amx_pkg
// Widths, register codes and shared types of the arcade drive mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package amx_pkg;

    // Port widths
    localparam int IN_W      = 16;
    localparam int CFG_W     = 16;
    localparam int OUT_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Register reset value (1.0 in Q8.8)
    localparam logic [CFG_W-1:0] CFG_RESET = 16'd256;

    // Internal datapath widths
    localparam int T_W    = 33;  // scaled throttle / turn, 2^-23 units
    localparam int F_W    = 23;  // ramp factor, 2^-16 units
    localparam int PROD_W = 56;  // turn times ramp
    localparam int P_W    = 40;  // rounded to 2^-24 units
    localparam int PD_W   = 56;  // times drive width
    localparam int D_W    = 46;  // turn term, 2^-23 units
    localparam int LR_W   = 47;  // left / right, 2^-23 units
    localparam int MAG_W  = 46;  // magnitude of the smaller side
    localparam int M_W    = 62;  // magnitude times throttle max
    localparam int NUM_W  = 64;  // divider numerator
    localparam int DEN_W  = 47;  // divider denominator
    localparam int Q_W    = 32;  // divider quotient
    localparam int SAT_W  = 33;  // saturator input

    // Saturation bounds
    localparam logic signed [SAT_W-1:0] SAT_HI =
        $signed(SAT_W'((64'd1 << (OUT_W - 1)) - 64'd1));
    localparam logic signed [SAT_W-1:0] SAT_LO =
        -$signed(SAT_W'(64'd1 << (OUT_W - 1)));

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_LIMIT = 2'd0,
        REG_TURN_GAIN   = 2'd1,
        REG_TRACK_WIDTH = 2'd2
    } cfg_idx_t;

    // Sideband carried alongside the divider
    typedef struct packed {
        logic             left_big;
        logic             other_neg;
        logic             scaled;
        logic [CFG_W-1:0] tmax;
        logic [OUT_W-1:0] left_u;
        logic [OUT_W-1:0] right_u;
    } side_t;

    // Clamp a signed value into the output range
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = {1'b0, {(OUT_W - 1){1'b1}}};
        end
        else if (v < SAT_LO)
        begin
            r = {1'b1, {(OUT_W - 1){1'b0}}};
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/arcade_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// arcade_drive_mixer_top
// Joystick to left/right wheel speed mixer with overshoot normalization.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive throttle_cmd / turn_cmd with start high; a sample transfers
//   at each rising edge with start high and busy low. busy stays low, so a
//   new sample may transfer in every cycle.
//   Output: result_valid is high for exactly one cycle per sample, carrying
//   left_speed, right_speed and was_scaled. Results leave in input order.
//   Between the transfer and the result lie 10 mixer stages, 32 divider
//   stages (one quotient bit per stage for the normalization ratio) and one
//   output register. Throughput is one sample per cycle.
//   Config: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Index 0 speed limit, 1 turn gain, 2 track width; index 3
//   is ignored. Write only while no sample is in flight.
//   Reset: all registers read 1.0 (256), the pipeline is emptied.
//   The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "arcade_drive_mixer_top_defines.svh"

module arcade_drive_mixer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // sample channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [amx_pkg::IN_W-1:0]      throttle_cmd,
    input  wire logic [amx_pkg::IN_W-1:0]      turn_cmd,
    // result channel
    output logic                               result_valid,
    output logic [amx_pkg::OUT_W-1:0]          left_speed,
    output logic [amx_pkg::OUT_W-1:0]          right_speed,
    output logic                               was_scaled,
    // configuration channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [amx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [amx_pkg::CFG_W-1:0]     cfg_data
);
    import amx_pkg::*;

    localparam int FRONT_STAGES = 10;
    localparam int LATENCY      = FRONT_STAGES + Q_W + 1;

    // Rounding constants for the power-of-two divides
    localparam int SH_F  = 9;   // |T| / 512
    localparam int SH_P  = 15;  // U*F / 32768
    localparam int SH_D  = 10;  // P*W / 1024
    localparam int SH_O  = 15;  // output / 32768
    localparam logic [CFG_W:0] F_ONE = 17'h10000;

    logic accept;

    // Configuration registers
    logic [CFG_W-1:0] tmax_reg;
    logic [CFG_W-1:0] turn_gain_reg;
    logic [CFG_W-1:0] dw_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmax_reg      <= CFG_RESET;
            turn_gain_reg <= CFG_RESET;
            dw_reg        <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SPEED_LIMIT: tmax_reg      <= cfg_data;
                REG_TURN_GAIN:   turn_gain_reg <= cfg_data;
                REG_TRACK_WIDTH: dw_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg, s10_vld_reg;

    logic [CFG_W-1:0] s1_tm_reg, s2_tm_reg, s3_tm_reg, s4_tm_reg, s5_tm_reg;
    logic [CFG_W-1:0] s6_tm_reg, s7_tm_reg, s8_tm_reg;

    logic signed [T_W-1:0] s1_t_reg, s2_t_reg, s3_t_reg, s4_t_reg, s5_t_reg;
    logic signed [T_W-1:0] s1_u_reg, s2_u_reg;
    logic [F_W-1:0]            s2_f_reg;
    logic signed [PROD_W-1:0]  s3_prod_reg;
    logic signed [P_W-1:0]     s4_p_reg;
    logic signed [PD_W-1:0]    s5_pd_reg;
    logic signed [D_W-1:0]     s6_d_reg;
    logic signed [T_W-1:0]     s6_t_reg;
    logic signed [LR_W-1:0]    s7_l_reg, s7_r_reg;

    logic                     s8_left_big_reg, s8_other_neg_reg, s8_scaled_reg;
    logic [DEN_W-1:0]         s8_big_reg;
    logic [MAG_W-1:0]         s8_mag_reg;
    logic signed [SAT_W-1:0]  s8_lu_reg, s8_ru_reg;

    logic [M_W-1:0]   s9_m_reg;
    logic [DEN_W-1:0] s9_big_reg;
    side_t            s9_side_reg;

    logic [NUM_W-1:0] s10_num_reg;
    logic [DEN_W-1:0] s10_den_reg;
    side_t            s10_side_reg;

    // Stage combinational values
    logic signed [T_W-1:0]    s1_t_next, s1_u_next;
    logic [T_W-1:0]           s2_abs;
    logic [F_W-1:0]           s2_f_next;
    logic signed [PROD_W-1:0] s3_prod_next;
    logic [PROD_W-1:0]        s4_mag, s4_q;
    logic signed [P_W-1:0]    s4_p_next;
    logic signed [PD_W-1:0]   s5_pd_next;
    logic [PD_W-1:0]          s6_mag, s6_q;
    logic signed [D_W-1:0]    s6_d_next;
    logic signed [LR_W-1:0]   s7_l_next, s7_r_next;
    logic                     s8_left_big, s8_scaled;
    logic signed [LR_W-1:0]   s8_big, s8_other;
    logic [LR_W-1:0]          s8_omag, s8_lmag, s8_rmag, s8_lq, s8_rq;
    logic signed [SAT_W-1:0]  s8_lu, s8_ru;
    logic [M_W-1:0]           s9_m_next;
    side_t                    s9_side_next;

    // Stage 1: scale sticks by the maxima
    always_comb
    begin
        s1_t_next = T_W'($signed(throttle_cmd)) * T_W'($signed({1'b0, tmax_reg}));
        s1_u_next = T_W'($signed(turn_cmd)) * T_W'($signed({1'b0, turn_gain_reg}));
    end

    // Stage 2: ramp factor 1 + |T|/4
    always_comb
    begin
        s2_abs    = s1_t_reg[T_W-1] ? T_W'(-s1_t_reg) : T_W'(s1_t_reg);
        s2_f_next = F_W'(F_ONE) + F_W'((s2_abs + T_W'(1 << (SH_F - 1))) >> SH_F);
    end

    // Stage 3: turn times ramp
    always_comb
    begin
        s3_prod_next = PROD_W'(s2_u_reg) * PROD_W'($signed({1'b0, s2_f_reg}));
    end

    // Stage 4: round to 2^-24 units
    always_comb
    begin
        s4_mag    = s3_prod_reg[PROD_W-1] ? PROD_W'(-s3_prod_reg) : PROD_W'(s3_prod_reg);
        s4_q      = (s4_mag + PROD_W'(1 << (SH_P - 1))) >> SH_P;
        s4_p_next = s3_prod_reg[PROD_W-1] ? -$signed(s4_q[P_W-1:0]) : $signed(s4_q[P_W-1:0]);
    end

    // Stage 5: times drive width
    always_comb
    begin
        s5_pd_next = PD_W'(s4_p_reg) * PD_W'($signed({1'b0, dw_reg}));
    end

    // Stage 6: half width, round to 2^-23 units
    always_comb
    begin
        s6_mag    = s5_pd_reg[PD_W-1] ? PD_W'(-s5_pd_reg) : PD_W'(s5_pd_reg);
        s6_q      = (s6_mag + PD_W'(1 << (SH_D - 1))) >> SH_D;
        s6_d_next = s5_pd_reg[PD_W-1] ? -$signed(s6_q[D_W-1:0]) : $signed(s6_q[D_W-1:0]);
    end

    // Stage 7: left and right
    always_comb
    begin
        s7_l_next = LR_W'(s6_t_reg) - LR_W'(s6_d_reg);
        s7_r_next = LR_W'(s6_t_reg) + LR_W'(s6_d_reg);
    end

    // Stage 8: pick the larger side, overshoot test, unnormalized rounding
    always_comb
    begin
        s8_left_big = (s7_l_reg > s7_r_reg);
        s8_big      = s8_left_big ? s7_l_reg : s7_r_reg;
        s8_other    = s8_left_big ? s7_r_reg : s7_l_reg;
        s8_scaled   = (s8_big > LR_W'($signed({1'b0, s7_tm_reg, 15'b0})));
        s8_omag     = s8_other[LR_W-1] ? LR_W'(-s8_other) : LR_W'(s8_other);
        s8_lmag     = s7_l_reg[LR_W-1] ? LR_W'(-s7_l_reg) : LR_W'(s7_l_reg);
        s8_rmag     = s7_r_reg[LR_W-1] ? LR_W'(-s7_r_reg) : LR_W'(s7_r_reg);
        s8_lq       = (s8_lmag + LR_W'(1 << (SH_O - 1))) >> SH_O;
        s8_rq       = (s8_rmag + LR_W'(1 << (SH_O - 1))) >> SH_O;
        s8_lu       = s7_l_reg[LR_W-1] ? -$signed(s8_lq[SAT_W-1:0])
                                       : $signed(s8_lq[SAT_W-1:0]);
        s8_ru       = s7_r_reg[LR_W-1] ? -$signed(s8_rq[SAT_W-1:0])
                                       : $signed(s8_rq[SAT_W-1:0]);
    end

    // Stage 9: smaller side times throttle max, saturate plain outputs
    always_comb
    begin
        s9_m_next            = M_W'(s8_mag_reg) * M_W'(s8_tm_reg);
        s9_side_next.left_big  = s8_left_big_reg;
        s9_side_next.other_neg = s8_other_neg_reg;
        s9_side_next.scaled    = s8_scaled_reg;
        s9_side_next.tmax      = s8_tm_reg;
        s9_side_next.left_u    = sat_out(s8_lu_reg);
        s9_side_next.right_u   = sat_out(s8_ru_reg);
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= accept;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        s1_t_reg  <= s1_t_next;
        s1_u_reg  <= s1_u_next;
        s1_tm_reg <= tmax_reg;

        s2_t_reg  <= s1_t_reg;
        s2_u_reg  <= s1_u_reg;
        s2_f_reg  <= s2_f_next;
        s2_tm_reg <= s1_tm_reg;

        s3_t_reg    <= s2_t_reg;
        s3_prod_reg <= s3_prod_next;
        s3_tm_reg   <= s2_tm_reg;

        s4_t_reg  <= s3_t_reg;
        s4_p_reg  <= s4_p_next;
        s4_tm_reg <= s3_tm_reg;

        s5_t_reg  <= s4_t_reg;
        s5_pd_reg <= s5_pd_next;
        s5_tm_reg <= s4_tm_reg;

        s6_t_reg  <= s5_t_reg;
        s6_d_reg  <= s6_d_next;
        s6_tm_reg <= s5_tm_reg;

        s7_l_reg  <= s7_l_next;
        s7_r_reg  <= s7_r_next;
        s7_tm_reg <= s6_tm_reg;

        s8_left_big_reg  <= s8_left_big;
        s8_other_neg_reg <= s8_other[LR_W-1];
        s8_scaled_reg    <= s8_scaled;
        s8_big_reg       <= DEN_W'(s8_big);
        s8_mag_reg       <= s8_omag[MAG_W-1:0];
        s8_lu_reg        <= s8_lu;
        s8_ru_reg        <= s8_ru;
        s8_tm_reg        <= s7_tm_reg;

        s9_m_reg    <= s9_m_next;
        s9_big_reg  <= s8_big_reg;
        s9_side_reg <= s9_side_next;

        // numerator with half the divisor added for rounding
        s10_num_reg  <= NUM_W'(s9_m_reg) + NUM_W'(s9_big_reg >> 1);
        s10_den_reg  <= s9_big_reg;
        s10_side_reg <= s9_side_reg;
    end

    // ------------------------------------------------------------------
    // Normalization ratio
    // ------------------------------------------------------------------
    logic             div_vld;
    logic [Q_W-1:0]   div_quot;
    side_t            div_side;

    amx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s10_vld_reg),
        .in_num    (s10_num_reg),
        .in_den    (s10_den_reg),
        .in_side   (s10_side_reg),
        .out_valid (div_vld),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Output stage: sign the ratio, pick sides, register the result
    // ------------------------------------------------------------------
    logic signed [SAT_W-1:0] fin_q;
    logic [OUT_W-1:0]        fin_other;
    logic [OUT_W-1:0]        fin_tm;
    logic [OUT_W-1:0]        left_next, right_next;

    logic             result_valid_reg;
    logic [OUT_W-1:0] left_speed_reg, right_speed_reg;
    logic             was_scaled_reg;

    always_comb
    begin
        fin_q     = div_side.other_neg ? -$signed({1'b0, div_quot})
                                       : $signed({1'b0, div_quot});
        fin_other = sat_out(fin_q);
        fin_tm    = OUT_W'(div_side.tmax);
        if (div_side.scaled)
        begin
            // larger side lands exactly on throttle max
            left_next  = div_side.left_big ? fin_tm : fin_other;
            right_next = div_side.left_big ? fin_other : fin_tm;
        end
        else
        begin
            left_next  = div_side.left_u;
            right_next = div_side.right_u;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        left_speed_reg  <= left_next;
        right_speed_reg <= right_next;
        was_scaled_reg  <= div_side.scaled;
    end

    assign result_valid = result_valid_reg;
    assign left_speed   = left_speed_reg;
    assign right_speed  = right_speed_reg;
    assign was_scaled   = was_scaled_reg;

    // Every transfer yields a result after the fixed latency
`AMX_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, ##(LATENCY - 1) result_valid)
    // No result without a transfer the same latency earlier
`AMX_ASSERT_IMPL(a_no_orphan, clk, rst_n, result_valid, $past(accept, LATENCY))

endmodule

`default_nettype wire

// File: rtl/amx_div.sv
// ----------------------------------------------------------------------------
// amx_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "arcade_drive_mixer_top_defines.svh"

module amx_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [amx_pkg::NUM_W-1:0] in_num,
    input  wire logic [amx_pkg::DEN_W-1:0] in_den,
    input  wire amx_pkg::side_t            in_side,
    output logic                           out_valid,
    output logic [amx_pkg::Q_W-1:0]        out_quot,
    output amx_pkg::side_t                 out_side
);
    import amx_pkg::*;

    // Stage registers, index k holds the result of k quotient bits
    logic             vld_reg  [1:Q_W];
    logic [DEN_W-1:0] rem_reg  [1:Q_W];
    logic [Q_W-1:0]   num_reg  [1:Q_W];
    logic [DEN_W-1:0] den_reg  [1:Q_W];
    logic [Q_W-1:0]   quot_reg [1:Q_W];
    side_t            side_reg [1:Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic             cur_vld;
        logic [DEN_W-1:0] cur_rem;
        logic [Q_W-1:0]   cur_num;
        logic [DEN_W-1:0] cur_den;
        logic [Q_W-1:0]   cur_quot;
        side_t            cur_side;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        // Stage input: ports for the first stage, else previous stage
        if (k == 0)
        begin : g_first
            // upper numerator half is below the divisor by range
            assign cur_vld  = in_valid;
            assign cur_rem  = DEN_W'(in_num[NUM_W-1:Q_W]);
            assign cur_num  = in_num[Q_W-1:0];
            assign cur_den  = in_den;
            assign cur_quot = '0;
            assign cur_side = in_side;
        end
        else
        begin : g_next
            assign cur_vld  = vld_reg[k];
            assign cur_rem  = rem_reg[k];
            assign cur_num  = num_reg[k];
            assign cur_den  = den_reg[k];
            assign cur_quot = quot_reg[k];
            assign cur_side = side_reg[k];
        end

        // Shift in one numerator bit, subtract when it fits
        always_comb
        begin
            trial    = {cur_rem, cur_num[Q_W-1]};
            ge       = (trial >= {1'b0, cur_den});
            rem_next = ge ? DEN_W'(trial - {1'b0, cur_den}) : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            num_reg[k+1]  <= {cur_num[Q_W-2:0], 1'b0};
            den_reg[k+1]  <= cur_den;
            quot_reg[k+1] <= {cur_quot[Q_W-2:0], ge};
            side_reg[k+1] <= cur_side;
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign out_quot  = quot_reg[Q_W];
    assign out_side  = side_reg[Q_W];

    // A normalized item always ends with a proper remainder
`AMX_ASSERT_IMPL(a_rem_bound, clk, rst_n, vld_reg[Q_W] && side_reg[Q_W].scaled, rem_reg[Q_W] < den_reg[Q_W])

endmodule

`default_nettype wire
